### sv/hrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hrf_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int HDR_LIMIT_W    = 16;
	localparam int REQ_LIMIT_W    = 24;
	localparam int HDR_COUNT_W    = 17;
	localparam int OUT_COUNT_W    = 24;
	localparam int TDATA_IN_W     = 8;
	localparam int TDATA_OUT_W    = 80;

	localparam logic [HDR_LIMIT_W-1:0] MAX_HDR_RESET = 16'd16384;
	localparam logic [REQ_LIMIT_W-1:0] MAX_REQ_RESET = 24'd1048576;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	localparam logic [3:0] KEY_LEN = 4'd15;

	// register map, word index taken from paddr[2]
	localparam logic REG_MAX_HDR = 1'b0;
	localparam logic REG_MAX_REQ = 1'b1;

	// result status codes
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_RECV   = 3'd1;
	localparam logic [2:0] ST_DONE   = 3'd2;
	localparam logic [2:0] ST_HDR_BIG = 3'd3;
	localparam logic [2:0] ST_BAD_LEN = 3'd4;
	localparam logic [2:0] ST_TOO_BIG = 3'd5;
	localparam logic [2:0] ST_DISC   = 3'd6;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_HEAD = 7'b0000010,
		PH_BODY = 7'b0000100,
		PH_DONE = 7'b0001000,
		PH_EHDR = 7'b0010000,
		PH_ELEN = 7'b0100000,
		PH_EBIG = 7'b1000000
	} phase_t;

	typedef enum logic [4:0] {
		VP_NONE   = 5'b00001,
		VP_SKIP   = 5'b00010,
		VP_SIGN   = 5'b00100,
		VP_DIGITS = 5'b01000,
		VP_STOP   = 5'b10000
	} value_phase_t;

	// lower-case "content-length:"
	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			4'd14:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

	function automatic logic [2:0] status_of(input phase_t ph);
		logic [2:0] s;
		case (ph)
			PH_HEAD, PH_BODY: s = ST_RECV;
			PH_DONE:          s = ST_DONE;
			PH_EHDR:          s = ST_HDR_BIG;
			PH_ELEN:          s = ST_BAD_LEN;
			PH_EBIG:          s = ST_TOO_BIG;
			default:          s = ST_IDLE;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### sv/http_request_framer.sv
// HTTP request framer.
// Slave stream: one transfer per received byte. s_tdata carries the byte, s_tuser
// carries the event kind (0 = data byte, 1 = peer closed / error, back to idle).
// Master stream: one transfer per input transfer, in order, with the request
// status, the byte passed through (zero when not kept), the kept flag, the
// header length, the parsed Content-Length and the body byte count.
// APB port: word 0 = max header bytes (16 bit), word 4 = max request bytes
// (24 bit); write only while the stream is idle. pready is tied high.
// Path: an accepted byte passes an input register, then the result register,
// before it is presented on the master side.
// Throughput: one byte per cycle unless m_tready stalls the output; the per-byte
// key/terminator matchers and the times-ten length accumulator are combinational.
// Stall: when m_tready is low the result holds, the input register fills and
// s_tready drops one transfer later; nothing is dropped or repeated.
// Reset (arst_n low): framer idle, all counters zero, limits back to 16 KiB
// header and 1 MiB request.
`timescale 1ns / 1ps
`default_nettype none
module http_request_framer import hrf_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // [7:0] data_byte
	input  wire logic                   s_tuser,   // [0] op
	// master stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [2:0] status, [10:3] byte_out, [11] byte_kept, [27:12] header_length,
	// [51:28] content_length, [75:52] body_received, [79:76] zero
	output logic [TDATA_OUT_W-1:0]      m_tdata,
	// APB configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [2:0]             paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CB     = COUNT_BITS;
	localparam int PROD_W = CB + 4;
	localparam int SUM_W  = (CB + 1 > REQ_LIMIT_W) ? CB + 1 : REQ_LIMIT_W;
	localparam int CLW    = (CB > OUT_COUNT_W) ? CB : OUT_COUNT_W;
	localparam logic [CB-1:0]          COUNT_MAX = {CB{1'b1}};
	localparam logic [HDR_COUNT_W-1:0] HCNT_MAX  = {HDR_COUNT_W{1'b1}};
	localparam logic [OUT_COUNT_W-1:0] OUT_MAX   = {OUT_COUNT_W{1'b1}};

	function automatic logic [OUT_COUNT_W-1:0] clamp24(input logic [CB-1:0] x);
		logic [CLW-1:0] w;
		w = CLW'(x);
		return (w > CLW'(OUT_MAX)) ? OUT_MAX : w[OUT_COUNT_W-1:0];
	endfunction

	// ---------------- configuration ----------------
	logic [HDR_LIMIT_W-1:0] max_hdr_q;
	logic [REQ_LIMIT_W-1:0] max_req_q;
	logic                   cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hdr_q <= MAX_HDR_RESET;
			max_req_q <= MAX_REQ_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_MAX_HDR) max_hdr_q <= pwdata[HDR_LIMIT_W-1:0];
			else                         max_req_q <= pwdata[REQ_LIMIT_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_MAX_HDR) prdata = 32'(max_hdr_q);
		else                         prdata = 32'(max_req_q);
	end

	// ---------------- input register ----------------
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       in_xfer;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// ---------------- framer state ----------------
	phase_t                 phase_q, phase_n;
	logic [1:0]             tm_q, tm_n;
	logic [3:0]             km_q, km_n;
	logic                   found_q, found_n;
	value_phase_t           vp_q, vp_n;
	logic                   neg_q, neg_n;
	logic                   digit_q, digit_n;
	logic                   pcr_q, pcr_n;
	logic [CB-1:0]          acc_q, acc_n;
	logic [HDR_COUNT_W-1:0] hc_q, hc_n;
	logic [CB-1:0]          bc_q, bc_n;

	logic [2:0]             r_status;
	logic                   r_kept;
	logic [HDR_LIMIT_W-1:0] r_hlen;
	logic [OUT_COUNT_W-1:0] r_clen;
	logic [OUT_COUNT_W-1:0] r_body;

	logic [7:0]             lb;
	logic [PROD_W-1:0]      prod;
	logic [SUM_W-1:0]       total;
	logic                   add_dig;
	logic                   hdr_done;

	always_comb begin
		phase_n  = phase_q;
		tm_n     = tm_q;
		km_n     = km_q;
		found_n  = found_q;
		vp_n     = vp_q;
		neg_n    = neg_q;
		digit_n  = digit_q;
		pcr_n    = pcr_q;
		acc_n    = acc_q;
		hc_n     = hc_q;
		bc_n     = bc_q;
		r_status = ST_IDLE;
		r_kept   = 1'b0;
		r_hlen   = '0;
		r_clen   = '0;
		r_body   = '0;
		add_dig  = 1'b0;
		hdr_done = 1'b0;
		total    = '0;
		lb       = (byte_s1 inside {["A":"Z"]}) ? byte_s1 + 8'd32 : byte_s1;
		// acc * 10 + digit, saturated below
		prod     = (PROD_W'(acc_q) << 3) + (PROD_W'(acc_q) << 1) + PROD_W'(byte_s1[3:0]);

		if (op_s1) begin
			// close: report a drop only while a request is open
			r_status = (phase_q == PH_HEAD || phase_q == PH_BODY) ? ST_DISC : ST_IDLE;
			phase_n  = PH_IDLE;
			tm_n     = '0;
			km_n     = '0;
			found_n  = 1'b0;
			vp_n     = VP_NONE;
			neg_n    = 1'b0;
			digit_n  = 1'b0;
			pcr_n    = 1'b0;
			acc_n    = '0;
			hc_n     = '0;
			bc_n     = '0;
		end else begin
			if (phase_q == PH_IDLE || phase_q == PH_HEAD) begin
				// idle state is already cleared, so a byte there just opens the header
				phase_n = PH_HEAD;
				hc_n    = (hc_q == HCNT_MAX) ? hc_q : hc_q + 1'b1;
				if (hc_n > HDR_COUNT_W'(max_hdr_q)) begin
					phase_n = PH_EHDR;
				end else begin
					if (found_q) begin
						case (vp_q)
							VP_SKIP: begin
								if (byte_s1 == CHAR_LF && pcr_q) begin
									pcr_n = 1'b0;
									vp_n  = VP_STOP;
								end else if (byte_s1 == CHAR_CR) begin
									pcr_n = 1'b1;
								end else if (is_space(byte_s1)) begin
									pcr_n = 1'b0;
								end else begin
									pcr_n = 1'b0;
									if (byte_s1 == "+") begin
										vp_n = VP_SIGN;
									end else if (byte_s1 == "-") begin
										neg_n = 1'b1;
										vp_n  = VP_SIGN;
									end else if (is_digit(byte_s1)) begin
										add_dig = 1'b1;
									end else begin
										vp_n = VP_STOP;
									end
								end
							end
							VP_SIGN, VP_DIGITS: begin
								if (is_digit(byte_s1)) add_dig = 1'b1;
								else                   vp_n = VP_STOP;
							end
							default: ;
						endcase
						if (add_dig) begin
							acc_n   = (prod[PROD_W-1:CB] != '0) ? COUNT_MAX : prod[CB-1:0];
							digit_n = 1'b1;
							vp_n    = VP_DIGITS;
						end
					end else begin
						if (lb == key_char(km_q)) km_n = km_q + 1'b1;
						else                      km_n = (lb == "c") ? 4'd1 : 4'd0;
						if (km_n == KEY_LEN) begin
							found_n = 1'b1;
							km_n    = '0;
							vp_n    = VP_SKIP;
						end
					end

					// CR LF CR LF tracker
					if (byte_s1 == (tm_q[0] ? CHAR_LF : CHAR_CR)) begin
						tm_n = tm_q + 1'b1;
						if (tm_q == 2'd3) begin
							tm_n = '0;
							total = SUM_W'(hc_n) + SUM_W'(acc_n);
							if (found_n && (!digit_n || (neg_n && acc_n != '0))) begin
								acc_n   = '0;
								phase_n = PH_ELEN;
							end else if (total > SUM_W'(max_req_q)) begin
								phase_n = PH_EBIG;
							end else begin
								phase_n = (acc_n == '0) ? PH_DONE : PH_BODY;
							end
						end
					end else begin
						tm_n = (byte_s1 == CHAR_CR) ? 2'd1 : 2'd0;
					end
				end
				r_kept = (phase_n == PH_HEAD || phase_n == PH_BODY || phase_n == PH_DONE);
			end else if (phase_q == PH_BODY) begin
				bc_n = bc_q + 1'b1;
				if (bc_n >= acc_q) phase_n = PH_DONE;
				r_kept = 1'b1;
			end

			r_status = status_of(phase_n);
			hdr_done = (phase_n == PH_BODY || phase_n == PH_DONE ||
			            phase_n == PH_ELEN || phase_n == PH_EBIG);
			if (hdr_done) begin
				r_hlen = (hc_n > HDR_COUNT_W'(16'hFFFF)) ? 16'hFFFF : hc_n[HDR_LIMIT_W-1:0];
				r_clen = clamp24(acc_n);
			end
			r_body = clamp24(bc_n);
		end
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tm_q    <= '0;
			km_q    <= '0;
			found_q <= 1'b0;
			vp_q    <= VP_NONE;
			neg_q   <= 1'b0;
			digit_q <= 1'b0;
			pcr_q   <= 1'b0;
			acc_q   <= '0;
			hc_q    <= '0;
			bc_q    <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			tm_q    <= tm_n;
			km_q    <= km_n;
			found_q <= found_n;
			vp_q    <= vp_n;
			neg_q   <= neg_n;
			digit_q <= digit_n;
			pcr_q   <= pcr_n;
			acc_q   <= acc_n;
			hc_q    <= hc_n;
			bc_q    <= bc_n;
		end
	end

	// ---------------- result register ----------------
	logic [TDATA_OUT_W-1:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= {4'b0000, r_body, r_clen, r_hlen, r_kept,
			          (r_kept ? byte_s1 : 8'h00), r_status};
		end
	end

	assign m_tdata = res_q;

endmodule
`default_nettype wire

### bench/hrf_frame_checker.sv
`timescale 1ns / 1ps
// Watches both stream ports and the APB port, predicts every result of the
// framer and compares it field by field with what comes out.
module hrf_frame_checker import hrf_pkg::*; #(
	parameter logic OP_CLOSE = 1'b1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int          err_cnt,
	output int          pend_cnt
);

	// lowest field last, so the struct lines up with m_tdata[75:0]
	typedef struct packed {
		logic [23:0] body_seen;
		logic [23:0] body_len;
		logic [15:0] hdr_len;
		logic        kept;
		logic [7:0]  byte_out;
		logic [2:0]  status;
	} frame_result_t;

	localparam logic [23:0]      LEN_SAT  = 24'hFF_FFFF;
	localparam logic [16:0]      HDR_SAT  = 17'h1_FFFF;
	localparam logic [8*15-1:0]  KEY_TEXT = "content-length:";

	frame_result_t frame_results_q[$];
	int            errs;

	phase_t        ph;
	value_phase_t  vph;
	int unsigned   term_cnt;
	int unsigned   key_cnt;
	logic          key_seen;
	logic          neg;
	logic          has_digit;
	logic          cr_seen;
	logic [23:0]   len_acc;
	logic [23:0]   body_cnt;
	logic [16:0]   hdr_cnt;
	logic [15:0]   lim_hdr;
	logic [23:0]   lim_req;

	task automatic clear_request();
		ph        = PH_IDLE;
		vph       = VP_NONE;
		term_cnt  = 0;
		key_cnt   = 0;
		key_seen  = 1'b0;
		neg       = 1'b0;
		has_digit = 1'b0;
		cr_seen   = 1'b0;
		len_acc   = '0;
		body_cnt  = '0;
		hdr_cnt   = '0;
	endtask

	task automatic take_digit(input logic [7:0] b);
		logic [35:0] v;
		v = 36'(len_acc) * 36'd10 + 36'(b - "0");
		len_acc   = (v > 36'(LEN_SAT)) ? LEN_SAT : v[23:0];
		has_digit = 1'b1;
		vph       = VP_DIGITS;
	endtask

	// strtol-like value scan after the key
	task automatic value_char(input logic [7:0] b);
		logic dig;
		logic spc;
		dig = (b >= "0") && (b <= "9");
		spc = (b == " ") || ((b >= 8'h09) && (b <= 8'h0D));
		case (vph)
			VP_SKIP: begin
				if (b == CHAR_LF && cr_seen) begin
					cr_seen = 1'b0;
					vph     = VP_STOP;
				end else if (b == CHAR_CR) begin
					cr_seen = 1'b1;
				end else if (spc) begin
					cr_seen = 1'b0;
				end else begin
					cr_seen = 1'b0;
					if (b == "+") begin
						vph = VP_SIGN;
					end else if (b == "-") begin
						neg = 1'b1;
						vph = VP_SIGN;
					end else if (dig) begin
						take_digit(b);
					end else begin
						vph = VP_STOP;
					end
				end
			end
			VP_SIGN, VP_DIGITS: begin
				if (dig) take_digit(b);
				else vph = VP_STOP;
			end
			default: ;
		endcase
	endtask

	task automatic headers_done();
		if (key_seen && (!has_digit || (neg && len_acc != '0))) begin
			len_acc = '0;
			ph      = PH_ELEN;
		end else if (25'(hdr_cnt) + 25'(len_acc) > 25'(lim_req)) begin
			ph = PH_EBIG;
		end else begin
			ph = (len_acc == '0) ? PH_DONE : PH_BODY;
		end
	endtask

	task automatic header_char(input logic [7:0] b);
		logic [7:0] lc;
		lc = ((b >= "A") && (b <= "Z")) ? b + 8'd32 : b;
		if (hdr_cnt < HDR_SAT) hdr_cnt++;
		// size check wins over everything else on this byte
		if (hdr_cnt > 17'(lim_hdr)) begin
			ph = PH_EHDR;
			return;
		end
		if (key_seen) begin
			value_char(b);
		end else begin
			if (lc == KEY_TEXT[8*(14-key_cnt) +: 8]) key_cnt++;
			else key_cnt = (lc == "c") ? 1 : 0;
			if (key_cnt >= 15) begin
				key_seen = 1'b1;
				key_cnt  = 0;
				vph      = VP_SKIP;
			end
		end
		if (b == (term_cnt[0] ? CHAR_LF : CHAR_CR)) term_cnt++;
		else term_cnt = (b == CHAR_CR) ? 1 : 0;
		if (term_cnt >= 4) begin
			term_cnt = 0;
			headers_done();
		end
	endtask

	task automatic advance_framer(input logic op, input logic [7:0] b,
			output frame_result_t r);
		logic hdr_end;
		r = '0;
		if (op == OP_CLOSE) begin
			r.status = (ph == PH_HEAD || ph == PH_BODY) ? ST_DISC : ST_IDLE;
			clear_request();
			return;
		end
		if (ph == PH_IDLE) begin
			clear_request();
			ph = PH_HEAD;
		end
		if (ph == PH_HEAD) begin
			header_char(b);
			r.kept = (ph == PH_HEAD) || (ph == PH_BODY) || (ph == PH_DONE);
		end else if (ph == PH_BODY) begin
			body_cnt++;
			if (body_cnt >= len_acc) ph = PH_DONE;
			r.kept = 1'b1;
		end
		case (ph)
			PH_HEAD, PH_BODY: r.status = ST_RECV;
			PH_DONE:          r.status = ST_DONE;
			PH_EHDR:          r.status = ST_HDR_BIG;
			PH_ELEN:          r.status = ST_BAD_LEN;
			PH_EBIG:          r.status = ST_TOO_BIG;
			default:          r.status = ST_IDLE;
		endcase
		hdr_end = (ph == PH_BODY) || (ph == PH_DONE) || (ph == PH_ELEN) || (ph == PH_EBIG);
		if (r.kept) r.byte_out = b;
		if (hdr_end) begin
			r.hdr_len  = (hdr_cnt > 17'h0FFFF) ? 16'hFFFF : hdr_cnt[15:0];
			r.body_len = len_acc;
		end
		r.body_seen = body_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			clear_request();
			lim_hdr = MAX_HDR_RESET;
			lim_req = MAX_REQ_RESET;
			frame_results_q.delete();
			errs = 0;
			pend_cnt <= 0;
			err_cnt  <= 0;
		end else begin
			// results trail their byte through two registers, so compare first
			if (m_tvalid && m_tready) begin
				got = frame_result_t'(m_tdata[75:0]);
				if (frame_results_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("unexpected result status %0d byte %h kept %0b",
							got.status, got.byte_out, got.kept);
				end else begin
					want = frame_results_q.pop_front();
					if (got !== want) begin
						errs++;
						if (errs <= 10) begin
							$display("mismatch (exp/got): status %0d/%0d byte %h/%h kept %0b/%0b",
								want.status, got.status, want.byte_out, got.byte_out,
								want.kept, got.kept);
							$display("  hdr %0d/%0d len %0d/%0d body %0d/%0d",
								want.hdr_len, got.hdr_len, want.body_len, got.body_len,
								want.body_seen, got.body_seen);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				advance_framer(s_tuser, s_tdata, want);
				frame_results_q.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MAX_REQ) lim_req = pwdata[23:0];
				else lim_hdr = pwdata[15:0];
			end
			pend_cnt <= frame_results_q.size();
			err_cnt  <= errs;
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the HTTP request framer. The checker beside the
// block does all prediction; this module only makes traffic and decides.
module tb_top;
	import hrf_pkg::*;

	localparam logic OP_BYTE   = 1'b0;
	localparam logic OP_CLOSE  = 1'b1;
	localparam int   HOLD_CYCLES = 400;     // long receiver stall
	localparam int   RUN_LIMIT   = 300000;  // watchdog limit

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
	logic        s_tuser  = 1'b0; // [0] op
	logic        m_tready = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;

	wire         s_tready;
	wire         m_tvalid;
	// [2:0] status, [10:3] byte_out, [11] byte_kept, [27:12] header_length,
	// [51:28] content_length, [75:52] body_received, [79:76] zero
	wire [79:0]  m_tdata;
	wire [31:0]  prdata;
	wire         pready;

	int          err_cnt;
	int          pend_cnt;
	int          items_sent  = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          cycle_cnt   = 0;
	logic        hold_tog    = 1'b0;   // flipped to request one long stall
	logic        hold_seen   = 1'b0;
	int          hold_left   = 0;
	logic [8:0]  burst_q[$];           // {op, byte} of the next request

	http_request_framer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	hrf_frame_checker #(.OP_CLOSE(OP_CLOSE)) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.err_cnt  (err_cnt),
		.pend_cnt (pend_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= RUN_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus one long hold counted here. The
	// hold request arrives as a toggle so the main thread never races us.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// One byte or close event. Handshake is sampled right after the edge, so
	// s_tready is still the pre-edge value. valid stays up between transfers
	// unless a gap is drawn; each gap cycle is drawn on its own, so the sender
	// idles in about tx_idle_pct of its cycles.
	task automatic put_item(input logic op, input logic [7:0] b);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// limits only change with the framer quiet
	task automatic set_limits(input logic [15:0] hdr, input logic [23:0] req);
		drain();
		apb_write(REG_MAX_HDR, {16'd0, hdr});
		apb_write(REG_MAX_REQ, {8'd0, req});
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) burst_q.push_back({OP_BYTE, s[i]});
	endtask

	task automatic send_burst();
		logic [8:0] x;
		while (burst_q.size() != 0) begin
			x = burst_q.pop_front();
			put_item(x[8], x[7:0]);
		end
	endtask

	// Builds one request: mostly well-formed with random content, some noise,
	// truncated requests and decoys for the key matcher.
	task automatic queue_request();
		string      key_s;
		int         sel;
		int         n;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			// raw noise, close events mixed in
			n = $urandom_range(1, 8);
			repeat (n) burst_q.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
			return;
		end
		if ($urandom_range(0, 1)) push_text("POST /form HTTP/1.1\015\012");
		else                      push_text("GET / HTTP/1.0\015\012");
		if ($urandom_range(0, 3) == 0) push_text("Content-Type: text\015\012");
		if ($urandom_range(0, 7) == 0) push_text("Content-Len: 3\015\012");
		if ($urandom_range(0, 99) < 85) begin
			key_s = "content-length:";
			if ($urandom_range(0, 9) == 0) push_text("X-c");   // restart on a stray c
			for (int i = 0; i < key_s.len(); i++) begin
				c = key_s[i];
				if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
				burst_q.push_back({OP_BYTE, c});
			end
			// leading whitespace, a bare CR LF ends the value early
			case ($urandom_range(0, 6))
				0:       ;
				1, 2:    push_text(" ");
				3:       push_text("\011");
				4:       push_text(" \013\014 ");
				5:       push_text("\015 ");
				default: push_text("\015\012 ");
			endcase
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				push_text("-0");
			end else begin
				if (sel < 12) push_text("-");
				else if (sel < 18) push_text("+");
				sel = $urandom_range(0, 99);
				if (sel < 8) ;                               // no digits
				else if (sel < 13) push_text("99999999999");  // saturates
				else if (sel < 17) push_text("16777215");
				else if (sel < 22) push_text("0");
				else if (sel < 27) push_text($sformatf("%0d", $urandom_range(41, 300)));
				else push_text($sformatf("%0d", $urandom_range(0, 40)));
			end
			if ($urandom_range(0, 9) == 0) push_text(" x");
			push_text("\015\012");
			// only the first key counts
			if ($urandom_range(0, 9) == 0) push_text("content-length: 5\015\012");
		end
		push_text("Host: h");
		n = $urandom_range(0, 4);
		repeat (n) burst_q.push_back({OP_BYTE, 8'($urandom_range(65, 90)) + ($urandom_range(0, 1) ? 8'd32 : 8'd0)});
		push_text("\015\012\015\012");
		n = $urandom_range(0, 45);
		repeat (n) burst_q.push_back({OP_BYTE, 8'($urandom_range(0, 255))});
		if ($urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, burst_q.size());
			while (burst_q.size() > n) void'(burst_q.pop_back());
		end
		if ($urandom_range(0, 99) < 85) burst_q.push_back({OP_CLOSE, 8'($urandom_range(0, 255))});
	endtask

	task automatic run_requests(input int until_items);
		while (items_sent < until_items) begin
			queue_request();
			send_burst();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles a third of the time, receiver most of the time
		tx_idle_pct = 33;
		rx_idle_pct = 73;

		// close while idle reports idle; close mid-request reports disconnect
		put_item(OP_CLOSE, 8'h00);
		put_item(OP_BYTE, 8'h00);
		put_item(OP_BYTE, 8'hFF);
		put_item(OP_CLOSE, 8'hFF);
		// bare terminator completes with no length, later byte is ignored
		push_text("\015\012\015\012");
		send_burst();
		put_item(OP_BYTE, 8'h5A);
		put_item(OP_CLOSE, 8'h00);

		// terminator lands on the byte that breaks the header limit
		set_limits(16'd3, 24'hFF_FFFF);
		push_text("\015\012\015\012");
		send_burst();
		put_item(OP_CLOSE, 8'h00);
		// header fits but header plus body exceeds a one byte total
		set_limits(16'd4, 24'd1);
		push_text("\015\012\015\012");
		send_burst();
		put_item(OP_CLOSE, 8'h00);
		// zero header limit rejects the first byte
		set_limits(16'd0, 24'hFF_FFFF);
		put_item(OP_BYTE, 8'h41);
		put_item(OP_CLOSE, 8'h00);
		// smallest legal header limit
		set_limits(16'd1, 24'hFF_FFFF);
		push_text("\015\012");
		send_burst();
		put_item(OP_CLOSE, 8'h00);

		// random traffic at reset limits
		set_limits(MAX_HDR_RESET, MAX_REQ_RESET);
		run_requests(700);

		// swap the idling sides; tight limits so both size errors show up
		tx_idle_pct = 73;
		rx_idle_pct = 33;
		set_limits(16'hFFFF, 24'd1);
		run_requests(760);
		set_limits(16'($urandom_range(24, 70)), 24'($urandom_range(40, 110)));
		run_requests(1080);
		set_limits(16'($urandom_range(24, 70)), 24'($urandom_range(40, 110)));
		run_requests(1400);

		// no idling; widest limits
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limits(16'hFFFF, 24'hFF_FFFF);
		// long receiver stall while we keep offering: input side must back up
		hold_tog <= ~hold_tog;
		run_requests(1700);
		// sender pause until everything is out
		drain();
		run_requests(2050);

		drain();
		repeat (10) @(posedge clk);
		if (err_cnt == 0 && pend_cnt == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
